// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle implication violated");

`endif

// ===== rtl/dmxtx_pkg.sv =====
// Shared types and constants of the DMX512 frame transmitter.
// Depends on nothing; imported by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package dmxtx_pkg;

  // Field widths
  localparam int LEN_W   = 10;
  localparam int PHASE_W = 5;
  localparam int BYTE_W  = 8;

  // Frame timing in bit periods
  localparam int BREAK_TICKS  = 22;
  localparam int MARK_TICKS   = 2;
  localparam int SLOT_TICKS   = 11;
  localparam int DATA_BITS    = 8;
  localparam int RESET_LENGTH = 16;

  localparam int CHANNELS_DEFAULT = 512;

  // Request codes
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_START = 2'd2,
    REQ_STOP  = 2'd3
  } req_type_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_MAX_CHANNEL = 1'b0,
    CFG_SINGLE_SHOT = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/dmx512_frame_transmitter_unit.sv =====
// DMX512 frame transmitter top level: request decode, frame sequencer, result register.
// Depends on dmxtx_pkg and dmxtx_ram.
`timescale 1ns / 1ps
`default_nettype none

// Takes one request per clock unless stalled and returns its result in the next cycle
// through a single output register; a new request is taken while the previous result
// waits, as long as that result is taken in the same cycle. Each tick request is one
// DMX bit period and yields the line level: a 22-period low break, a 2-period mark,
// then 11-period slots (start bit, 8 data bits LSB first, 2 stop bits), start code
// first, then channels 1 to the frame length. The channel bytes live in a
// CHANNELS-deep RAM; after reset a clearing pass zeroes it, one entry per cycle, so
// in_ready stays low until the pass ends (configuration writes are still taken).
module dmx512_frame_transmitter_unit
  import dmxtx_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // Configuration
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [LEN_W-1:0] cfg_data,
  // Request channel
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       req_type,
  input  wire logic [LEN_W-1:0] channel_index,
  input  wire logic [7:0]       write_value,
  // Result channel
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  line_level,
  output logic                  running,
  output logic                  frame_end
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(CHANNELS);
  localparam logic [LEN_W-1:0] RESET_LEN =
    (RESET_LENGTH > CHANNELS) ? LEN_W'(CHANNELS) : LEN_W'(RESET_LENGTH);

  // Sequencer state
  logic [LEN_W-1:0]   frame_length, frame_length_next;
  logic [LEN_W-1:0]   slot_position, slot_position_next;
  logic [PHASE_W-1:0] tick_in_phase, tick_in_phase_next;
  logic               in_break_phase, in_break_phase_next;
  logic               transmitting, transmitting_next;
  logic               start_slot, start_slot_next;
  logic               single_shot;

  // Clearing pass
  logic               clearing;
  logic [AW-1:0]      clr_addr;

  // Store access
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]  ram_wdata, ram_rdata;
  logic [LEN_W-1:0]   ch_minus1, pos_minus1;
  logic [BYTE_W-1:0]  slot_byte;
  logic [2:0]         bit_idx;

  logic               accept, ch_ok, wr_req;
  logic               level_d, running_d, fend_d;

  assign accept   = in_valid && in_ready;
  assign in_ready = !clearing && (!out_valid || out_ready);

  assign ch_ok  = (channel_index != '0) && (channel_index <= MAX_LEN);
  assign wr_req = accept && (req_type == REQ_WRITE) && ch_ok;

  assign ch_minus1  = channel_index - LEN_W'(1);
  assign pos_minus1 = slot_position - LEN_W'(1);

  // The start code slot carries zero; other slots come from the store
  assign slot_byte = start_slot ? '0 : ram_rdata;
  assign bit_idx   = 3'(tick_in_phase - PHASE_W'(1));

  // Decode one request: next state and the result it yields
  always_comb begin
    frame_length_next   = frame_length;
    slot_position_next  = slot_position;
    tick_in_phase_next  = tick_in_phase;
    in_break_phase_next = in_break_phase;
    transmitting_next   = transmitting;
    start_slot_next     = start_slot;
    ram_re              = 1'b0;
    level_d             = 1'b1;
    fend_d              = 1'b0;
    running_d           = transmitting;
    if (accept) begin
      case (req_type)
        REQ_TICK: begin
          if (transmitting) begin
            if (in_break_phase) begin
              level_d = (tick_in_phase < PHASE_W'(BREAK_TICKS)) ? 1'b0 : 1'b1;
              if (tick_in_phase >= PHASE_W'(BREAK_TICKS + MARK_TICKS - 1)) begin
                in_break_phase_next = 1'b0;
                tick_in_phase_next  = '0;
              end else begin
                tick_in_phase_next = tick_in_phase + PHASE_W'(1);
              end
            end else begin
              if (tick_in_phase == '0) begin
                // Start bit: fetch the slot byte for the data bits that follow
                ram_re          = 1'b1;
                start_slot_next = (slot_position == '0);
                level_d         = 1'b0;
              end else if (tick_in_phase <= PHASE_W'(DATA_BITS)) begin
                level_d = slot_byte[bit_idx];
              end else begin
                level_d = 1'b1;
              end
              if (tick_in_phase >= PHASE_W'(SLOT_TICKS - 1)) begin
                tick_in_phase_next = '0;
                if (slot_position >= frame_length) begin
                  fend_d              = 1'b1;
                  slot_position_next  = '0;
                  in_break_phase_next = 1'b1;
                  if (single_shot) begin
                    transmitting_next = 1'b0;
                  end
                end else begin
                  slot_position_next = slot_position + LEN_W'(1);
                end
              end else begin
                tick_in_phase_next = tick_in_phase + PHASE_W'(1);
              end
            end
          end
        end
        REQ_WRITE: begin
          if (ch_ok && (channel_index > frame_length)) begin
            frame_length_next = channel_index;
          end
        end
        REQ_START: begin
          transmitting_next   = 1'b1;
          slot_position_next  = '0;
          tick_in_phase_next  = '0;
          in_break_phase_next = 1'b1;
          running_d           = 1'b1;
        end
        REQ_STOP: begin
          transmitting_next = 1'b0;
          running_d         = 1'b0;
        end
        default: begin
          transmitting_next = transmitting;
        end
      endcase
    end
    // Configuration load wins; the user ensures it arrives only while idle, unchecked
    if (cfg_we && (cfg_index == CFG_MAX_CHANNEL)) begin
      frame_length_next = (cfg_data > MAX_LEN) ? MAX_LEN : cfg_data;
    end
  end

  // Store port selection: clearing pass, then request writes
  always_comb begin
    ram_we    = clearing || wr_req;
    ram_waddr = clearing ? clr_addr : ch_minus1[AW-1:0];
    ram_wdata = clearing ? '0 : write_value;
    ram_raddr = pos_minus1[AW-1:0];
  end

  dmxtx_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (CHANNELS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length   <= RESET_LEN;
      slot_position  <= '0;
      tick_in_phase  <= '0;
      in_break_phase <= 1'b1;
      transmitting   <= 1'b0;
      start_slot     <= 1'b1;
      single_shot    <= 1'b0;
    end else begin
      frame_length   <= frame_length_next;
      slot_position  <= slot_position_next;
      tick_in_phase  <= tick_in_phase_next;
      in_break_phase <= in_break_phase_next;
      transmitting   <= transmitting_next;
      start_slot     <= start_slot_next;
      if (cfg_we && (cfg_index == CFG_SINGLE_SHOT)) begin
        single_shot <= cfg_data[0];
      end
    end
  end

  // Sweep the store to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(CHANNELS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_level <= level_d;
      running    <= running_d;
      frame_end  <= fend_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dmxtx_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module dmxtx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dmxtx_checker.sv =====
// Port-level checker for the DMX512 frame transmitter, bound to the top level.
// Depends on dmxtx_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dmxtx_checker
  import dmxtx_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] req_type,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       line_level,
  input wire logic       running,
  input wire logic       frame_end
);

  logic nontick_req;

  // Flag an accepted request that is not a tick
  assign nontick_req = in_valid && in_ready && (req_type != REQ_TICK);

  // Hold a result until it is taken
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // No new request while a stalled result occupies the output register
  `ASSERT_IMPL(a_no_overrun, clk, rst, out_valid && !out_ready, !in_ready)

  // Frame end falls on a transmitted stop bit
  `ASSERT_IMPL(a_fend_stop, clk, rst, out_valid && frame_end, running && line_level)

  // Idle line is high
  `ASSERT_IMPL(a_idle_high, clk, rst, out_valid && !running, line_level)

  // A request other than a tick yields an idle level and no frame end
  `ASSERT_NEXT(a_nontick_idle, clk, rst, nontick_req, out_valid && line_level && !frame_end)

endmodule

bind dmx512_frame_transmitter_unit dmxtx_checker u_dmxtx_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .req_type   (req_type),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .line_level (line_level),
  .running    (running),
  .frame_end  (frame_end)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the DMX512 frame transmitter unit.
// Depends on dmxtx_pkg and dmx512_frame_transmitter_unit; uses no other files.
`timescale 1ns / 1ps

module tb_top;
  import dmxtx_pkg::*;

  localparam int NUM_CH          = CHANNELS_DEFAULT;
  localparam int ITEMS_PER_PHASE = 88;
  localparam int SETTLE_CYCLES   = 4;
  localparam int LONG_HOLD       = 80;
  localparam int NUM_PHASES      = 9;
  localparam int N_DIRECTED      = 20;

  // One result: line level, running flag, frame end
  typedef struct packed {
    logic line;
    logic run;
    logic fend;
  } dmx_result_t;

  localparam dmx_result_t RES_IDLE      = '{line: 1'b1, run: 1'b0, fend: 1'b0};
  localparam dmx_result_t RES_RUN_MARK  = '{line: 1'b1, run: 1'b1, fend: 1'b0};
  localparam dmx_result_t RES_RUN_SPACE = '{line: 1'b0, run: 1'b1, fend: 1'b0};

  typedef struct {
    req_type_t   r;
    logic [9:0]  ch;
    logic [7:0]  v;
    bit          typed;
    dmx_result_t res;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [0:0]       cfg_index = CFG_MAX_CHANNEL;
  logic [LEN_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  req_type_t        req_type = REQ_TICK;
  logic [LEN_W-1:0] channel_index = '0;
  logic [7:0]       write_value = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             line_level;
  logic             running;
  logic             frame_end;

  dmx512_frame_transmitter_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .channel_index (channel_index),
    .write_value   (write_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .line_level    (line_level),
    .running       (running),
    .frame_end     (frame_end)
  );

  always #5 clk = ~clk;

  // Transmitter state as the testbench tracks it
  logic [7:0]  chan_bytes [1:NUM_CH];
  logic [9:0]  frame_len;
  logic [9:0]  slot_pos;
  logic [4:0]  phase_tick;
  logic        in_break;
  logic        xmit;
  logic        one_frame;
  logic [7:0]  cur_byte;

  dmx_result_t expected_levels [$];
  int          errors = 0;
  int          results_taken = 0;
  bit          calm = 1'b0;

  // Directed rows: stopped ticks, bad and good writes, start, restart, stop mid-frame
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{REQ_TICK,  10'd0,    8'h00, 1'b1, RES_IDLE},
    '{REQ_STOP,  10'd0,    8'h00, 1'b1, RES_IDLE},
    '{REQ_WRITE, 10'd0,    8'hFF, 1'b1, RES_IDLE},
    '{REQ_WRITE, 10'd1023, 8'hFF, 1'b1, RES_IDLE},
    '{REQ_WRITE, 10'd513,  8'hAA, 1'b1, RES_IDLE},
    '{REQ_WRITE, 10'd1,    8'hA5, 1'b1, RES_IDLE},
    '{REQ_WRITE, 10'd2,    8'hFF, 1'b1, RES_IDLE},
    '{REQ_WRITE, 10'd3,    8'h00, 1'b1, RES_IDLE},
    '{REQ_START, 10'd0,    8'h00, 1'b1, RES_RUN_MARK},
    '{REQ_TICK,  10'd0,    8'h00, 1'b1, RES_RUN_SPACE},
    '{REQ_TICK,  10'd1023, 8'hFF, 1'b0, RES_IDLE},
    '{REQ_START, 10'd0,    8'h00, 1'b1, RES_RUN_MARK},
    '{REQ_TICK,  10'd0,    8'h00, 1'b1, RES_RUN_SPACE},
    '{REQ_STOP,  10'd0,    8'h00, 1'b1, RES_IDLE},
    '{REQ_TICK,  10'd0,    8'h00, 1'b1, RES_IDLE},
    '{REQ_WRITE, 10'd512,  8'h5A, 1'b1, RES_IDLE},
    '{REQ_START, 10'd0,    8'h00, 1'b1, RES_RUN_MARK},
    '{REQ_TICK,  10'd0,    8'h00, 1'b0, RES_IDLE},
    '{REQ_TICK,  10'd0,    8'h00, 1'b0, RES_IDLE},
    '{REQ_TICK,  10'd0,    8'h00, 1'b0, RES_IDLE}
  };

  // Frame length and single-shot setting per phase; the last ones are drawn at random
  int phase_len  [7] = '{0, 3, 512, 1, 16, 4, 2};
  bit phase_shot [7] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

  function automatic void reset_model();
    for (int i = 1; i <= NUM_CH; i++) chan_bytes[i] = 8'h00;
    frame_len  = 10'(RESET_LENGTH);
    slot_pos   = '0;
    phase_tick = '0;
    in_break   = 1'b1;
    xmit       = 1'b0;
    one_frame  = 1'b0;
    cur_byte   = '0;
  endfunction

  function automatic void apply_reg(input cfg_reg_t idx, input logic [9:0] val);
    if (idx == CFG_MAX_CHANNEL) begin
      frame_len = (val > NUM_CH) ? 10'(NUM_CH) : val;
    end else begin
      one_frame = val[0];
    end
  endfunction

  // Advance the tracked state by one request and return its result;
  // effective is low for ticks while stopped and for writes to channels out of range
  function automatic dmx_result_t predict_line(input req_type_t r, input logic [9:0] ch,
                                               input logic [7:0] v, output bit effective);
    dmx_result_t res;
    res = RES_IDLE;
    effective = 1'b1;
    case (r)
      REQ_TICK: begin
        if (!xmit) begin
          effective = 1'b0;
        end else begin
          res.run = 1'b1;
          if (in_break) begin
            // low for the break, high for the mark after it
            res.line = (phase_tick >= BREAK_TICKS);
            if (phase_tick + 1 >= BREAK_TICKS + MARK_TICKS) begin
              in_break   = 1'b0;
              phase_tick = '0;
            end else begin
              phase_tick = phase_tick + 1'b1;
            end
          end else begin
            // start bit, data bits LSB first, stop bits
            if (phase_tick == 0) begin
              cur_byte = (slot_pos == 0 || slot_pos > NUM_CH) ? 8'h00 : chan_bytes[slot_pos];
              res.line = 1'b0;
            end else if (phase_tick <= DATA_BITS) begin
              res.line = cur_byte[phase_tick - 1];
            end else begin
              res.line = 1'b1;
            end
            if (phase_tick + 1 >= SLOT_TICKS) begin
              phase_tick = '0;
              if (slot_pos >= frame_len) begin
                res.fend = 1'b1;
                slot_pos = '0;
                in_break = 1'b1;
                if (one_frame) xmit = 1'b0;
              end else begin
                slot_pos = slot_pos + 1'b1;
              end
            end else begin
              phase_tick = phase_tick + 1'b1;
            end
          end
        end
      end
      REQ_WRITE: begin
        if (ch >= 1 && ch <= NUM_CH) begin
          chan_bytes[ch] = v;
          if (ch > frame_len) frame_len = ch;
        end else begin
          effective = 1'b0;
        end
      end
      REQ_START: begin
        xmit       = 1'b1;
        slot_pos   = '0;
        phase_tick = '0;
        in_break   = 1'b1;
      end
      default: xmit = 1'b0;
    endcase
    if (r != REQ_TICK) res.run = xmit;
    return res;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [9:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    apply_reg(idx, val);
  endtask

  // Offer one request, hold it until taken, then queue its expected result
  task automatic send_request(input req_type_t r, input logic [9:0] ch, input logic [7:0] v,
                              input bit typed, input dmx_result_t typed_res,
                              output bit effective);
    dmx_result_t res;
    in_valid      <= 1'b1;
    req_type      <= r;
    channel_index <= ch;
    write_value   <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = predict_line(r, ch, v, effective);
    expected_levels.push_back(typed ? typed_res : res);
  endtask

  task automatic sender_gap();
    int p;
    int gap;
    p = $urandom_range(0, 99);
    gap = 0;
    if (!calm) begin
      if (p >= 95) gap = $urandom_range(10, 30);
      else if (p >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [9:0] pick_channel();
    int q;
    q = $urandom_range(0, 99);
    if (q < 75) return 10'($urandom_range(1, 8));
    if (q < 84) return 10'd0;
    if (q < 92) return 10'($urandom_range(NUM_CH + 1, 1023));
    return 10'($urandom_range(1, NUM_CH));
  endfunction

  // Main sequence: reset, directed rows, then random phases with new settings
  initial begin : main_seq
    bit         eff;
    int         counted;
    int         p;
    req_type_t  r;
    logic [9:0] ch;
    logic [7:0] v;
    logic [9:0] len_set;
    bit         shot_set;

    reset_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_reg(CFG_MAX_CHANNEL, 10'(RESET_LENGTH));
    write_reg(CFG_SINGLE_SHOT, 10'd0);
    cfg_we <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_request(directed_rows[i].r, directed_rows[i].ch, directed_rows[i].v,
                   directed_rows[i].typed, directed_rows[i].res, eff);
      sender_gap();
    end
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 7) begin
        len_set  = 10'(phase_len[ph]);
        shot_set = phase_shot[ph];
      end else begin
        len_set  = 10'($urandom_range(0, 6));
        shot_set = 1'($urandom_range(0, 1));
      end
      write_reg(CFG_MAX_CHANNEL, len_set);
      write_reg(CFG_SINGLE_SHOT, {9'd0, shot_set});
      cfg_we <= 1'b0;
      calm = (ph % 3 == 2);

      // mostly ticks; restart quickly once stopped
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        p  = $urandom_range(0, 99);
        ch = 10'($urandom_range(0, 1023));
        v  = 8'($urandom_range(0, 255));
        if (!xmit && p < 25) r = REQ_START;
        else if (p < 84) r = REQ_TICK;
        else if (p < 98) begin
          r  = REQ_WRITE;
          ch = pick_channel();
        end else if (p < 99) r = REQ_START;
        else r = REQ_STOP;
        send_request(r, ch, v, 1'b0, RES_IDLE, eff);
        if (eff) counted++;
        sender_gap();
      end
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Receiver: random stalls, plus two long hold-offs that back up the request side
  initial begin : result_sink
    int hold_points [2];
    int hold_idx;
    int p;
    hold_points = '{150, 520};
    hold_idx = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      p = $urandom_range(0, 99);
      if (hold_idx < 2 && results_taken >= hold_points[hold_idx]) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_idx++;
      end else if (!calm && p < 15) begin
        out_ready <= 1'b0;
        if ($urandom_range(0, 99) < 15) repeat ($urandom_range(10, 40)) @(posedge clk);
        else repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin : result_check
    dmx_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_taken++;
      if (expected_levels.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want = expected_levels.pop_front();
        if (line_level !== want.line) begin
          $error("line_level: expected %0d, got %0d", want.line, line_level);
          errors++;
        end
        if (running !== want.run) begin
          $error("running: expected %0d, got %0d", want.run, running);
          errors++;
        end
        if (frame_end !== want.fend) begin
          $error("frame_end: expected %0d, got %0d", want.fend, frame_end);
          errors++;
        end
      end
    end
  end

  // Hard stop if the run hangs
  initial begin : watchdog
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
